### rtl/par_pkg.sv
package par_pkg;

  // Item opcodes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Report modes
  localparam logic [1:0] MODE_SUM   = 2'd0;
  localparam logic [1:0] MODE_AVG   = 2'd1;
  localparam logic [1:0] MODE_COUNT = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_TAKEN   = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_RESULT  = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_MODE        = 3'd0;
  localparam logic [2:0] REG_ROW_CAP     = 3'd1;
  localparam logic [2:0] REG_CLIP_LIMIT  = 3'd2;
  localparam logic [2:0] REG_SUM_SCALE   = 3'd3;
  localparam logic [2:0] REG_COUNT_SCALE = 3'd4;

  // ln(2) in Q30
  localparam logic [31:0] LN2_Q30 = 32'd744261118;
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  // Unsigned long division by shift and subtract, for elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln(1 + i/2^bits) in Q30 by the truncated atanh series, for elaboration only
  function automatic logic [31:0] ln_entry(input int i, input int bits);
    logic [63:0] f;
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] term;
    logic [63:0] acc;
    f = 64'(i) << (30 - bits);
    y = udiv64(f << 30, 2 * Q30_ONE + f);
    y2 = (y * y) >> 30;
    term = y;
    acc = 64'd0;
    for (int k = 1; k < 40; k += 2) begin
      acc = acc + udiv64(term, 64'(k));
      term = (term * y2) >> 30;
    end
    return 32'(2 * acc);
  endfunction

endpackage

### rtl/par_ram.sv
module par_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry into a register
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/private_aggregate_reservoir.sv
// Per-user reservoir sampling with Laplace-noised sum, count and average.
// A command is taken when start is high and busy is low; each command gives
// exactly one result, shown for one cycle with done high, which the receiver
// must take as it comes. The datapath holds one shared bit-serial divider
// (one quotient bit a cycle), a shift-by-one normalizer and a 32x32
// multiplier used four times. The home slot of a user is the low bits of
// user_id, so MAX_USERS must be a power of two. An add row reads and checks
// each probed slot; when the user is at its cap it runs the divider to draw a
// position, and replaces the kept value there unless the drawn position misses
// the kept values. A sum or count report makes its noise with one normalizer
// shift per leading zero of the noise magnitude, then the table and four
// multiply-accumulate rounds; an average makes two noises and then a
// division. A clear, and the pass that follows reset, walks every slot of the
// slot table with busy high; configuration writes are always taken.
module private_aggregate_reservoir #(
  parameter int MAX_USERS      = 1024,
  parameter int MAX_CAP        = 16,
  parameter int LOG_TABLE_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic signed [31:0] user_id,
  input  logic signed [31:0] row_value,
  input  logic [31:0] pick_draw,
  input  logic [31:0] noise_draw_a,
  input  logic [31:0] noise_draw_b,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic        done,
  output logic [1:0]  status,
  output logic signed [63:0] result
);

  import par_pkg::*;

  localparam int UW  = $clog2(MAX_USERS);
  localparam int KW  = $clog2(MAX_CAP + 1);
  localparam int VD  = MAX_USERS * MAX_CAP;
  localparam int VW  = $clog2(VD);
  localparam int TCW = $clog2(VD + 1);
  localparam int MW  = 1 + 32 + 32 + KW;
  localparam int TAB_SIZE = 1 << LOG_TABLE_BITS;
  localparam logic [63:0] SMAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] SMIN = {1'b1, 63'd0};

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_PROBE_RD, S_PROBE_CHK, S_PICK, S_VAL_RD,
    N_NORM, N_TAB, N_LNV, N_MUL, N_ACC, N_SUM
  } state_t;

  typedef enum logic [1:0] {DV_PICK, DV_AVG} div_op_t;

  state_t state;
  div_op_t div_op;

  // Configuration
  logic [1:0]  mode;
  logic [4:0]  row_cap;
  logic [30:0] clip_limit;
  logic [62:0] sum_noise_scale;
  logic [62:0] count_noise_scale;

  // Totals and command registers
  logic signed [63:0] total_sum;
  logic [TCW-1:0]     total_count;
  logic [31:0]        key_r;
  logic signed [31:0] val_r;
  logic [31:0]        draw_r;
  logic [31:0]        db_r;
  logic               clr_report;
  logic [UW-1:0]      clr_cnt;

  // Probe and reservoir
  logic [UW-1:0] slot;
  logic [UW-1:0] probe_n;
  logic [VW-1:0] val_addr;

  // Divider
  logic [63:0] rem;
  logic [79:0] quo;
  logic [63:0] dvs;
  logic [6:0]  dcnt;
  logic        dneg;

  // Noise unit
  logic [31:0]  mn;
  logic [4:0]   nz;
  logic         npos;
  logic [31:0]  tabv;
  logic [35:0]  zl;
  logic [34:0]  lnv;
  logic [63:0]  scale;
  logic [1:0]   mstep;
  logic [63:0]  prod;
  logic [127:0] acc;
  logic [63:0]  base;
  logic         pass;
  logic [63:0]  ns;

  // Memories
  logic          meta_we;
  logic [UW-1:0] meta_waddr;
  logic [MW-1:0] meta_wdata;
  logic [MW-1:0] meta_rdata;
  logic          val_we;
  logic [VW-1:0] val_waddr;
  logic [31:0]   val_wdata;
  logic [31:0]   val_rdata;

  par_ram #(.WIDTH(MW), .DEPTH(MAX_USERS)) u_meta (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(slot), .rdata(meta_rdata)
  );

  par_ram #(.WIDTH(32), .DEPTH(VD)) u_vals (
    .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
    .raddr(val_addr), .rdata(val_rdata)
  );

  // Log table
  logic [31:0] ln_tab [TAB_SIZE];
  for (genvar gi = 0; gi < TAB_SIZE; gi++) begin : g_tab
    localparam logic [31:0] LN_V = ln_entry(gi, LOG_TABLE_BITS);
    assign ln_tab[gi] = LN_V;
  end

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? SMIN : SMAX;
    end
    return s[63:0];
  endfunction

  function automatic logic [31:0] noise_mag(input logic [31:0] d);
    logic [32:0] m;
    m = d[31] ? (33'h1_0000_0000 - {1'b0, d}) : {1'b0, d};
    if (m == 33'd0) begin
      m = 33'd1;
    end
    return m[31:0];
  endfunction

  // Effective cap, clamped to 1..MAX_CAP
  logic [KW-1:0] cap;
  always_comb begin
    if (row_cap == 5'd0) begin
      cap = KW'(1);
    end else if (32'(row_cap) > 32'(MAX_CAP)) begin
      cap = KW'(MAX_CAP);
    end else begin
      cap = KW'(row_cap);
    end
  end

  // Clipped row value
  logic signed [31:0] clip_v;
  always_comb begin
    logic signed [32:0] v33;
    logic signed [32:0] lim;
    v33 = {row_value[31], row_value};
    lim = $signed({2'b00, clip_limit});
    if (mode == MODE_COUNT) begin
      v33 = 33'sd0;
    end
    if (v33 > lim) begin
      v33 = lim;
    end
    if (v33 < -lim) begin
      v33 = -lim;
    end
    clip_v = v33[31:0];
  end

  // Slot check on the read entry
  logic          m_used;
  logic [31:0]   m_key;
  logic [31:0]   m_seen;
  logic [KW-1:0] m_kept;
  logic          hit;
  logic [31:0]   seen_n;
  logic [KW-1:0] kept0;
  logic          append;
  assign {m_used, m_key, m_seen, m_kept} = meta_rdata;
  assign hit = !m_used || (m_key == key_r);
  assign kept0 = m_used ? m_kept : '0;
  always_comb begin
    logic [31:0] seen0;
    seen0 = m_used ? m_seen : 32'd0;
    seen_n = (seen0 == 32'hFFFF_FFFF) ? seen0 : seen0 + 32'd1;
  end
  assign append = kept0 < cap;

  logic [VW-1:0] slot_base;
  assign slot_base = VW'(slot) * VW'(MAX_CAP);

  // Memory writes: clearing sweep, slot update or kept value replacement
  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = slot;
    meta_wdata = {1'b1, key_r, seen_n, append ? kept0 + KW'(1) : kept0};
    val_we     = 1'b0;
    val_waddr  = slot_base + VW'(kept0);
    val_wdata  = val_r;
    if (state == S_CLEAR) begin
      meta_we    = 1'b1;
      meta_waddr = clr_cnt;
      meta_wdata = '0;
    end else if (state == S_PROBE_CHK && hit) begin
      meta_we = 1'b1;
      val_we  = append;
    end else if (state == S_VAL_RD) begin
      val_waddr = val_addr;
      val_we    = 1'b1;
    end
  end

  // Divider step
  logic [64:0] dv_t;
  logic        dv_ge;
  logic [64:0] dv_sub;
  assign dv_t   = {rem, quo[79]};
  assign dv_ge  = dv_t >= {1'b0, dvs};
  assign dv_sub = dv_t - {1'b0, dvs};

  // Multiplier operands
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  always_comb begin
    mul_a = mstep[1] ? scale[63:32] : scale[31:0];
    mul_b = (mstep == 2'd1 || mstep == 2'd3) ? {29'd0, lnv[34:32]} : lnv[31:0];
  end

  logic [6:0] acc_sh;
  always_comb begin
    case (mstep)
      2'd0:    acc_sh = 7'd0;
      2'd3:    acc_sh = 7'd64;
      default: acc_sh = 7'd32;
    endcase
  end

  // Noise magnitude and noisy sum
  logic [63:0] n_mag;
  logic [63:0] n_sum;
  assign n_mag = (|acc[127:93]) ? SMAX : {1'b0, acc[92:30]};
  assign n_sum = sat_add(base, npos ? n_mag : 64'(-n_mag));

  logic [63:0] cnt_q16;
  assign cnt_q16 = 64'(total_count) << 16;

  assign busy = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_CLEAR;
      clr_cnt           <= '0;
      clr_report        <= 1'b0;
      done              <= 1'b0;
      mode              <= MODE_SUM;
      row_cap           <= 5'd16;
      clip_limit        <= 31'd65536;
      sum_noise_scale   <= 63'd65536;
      count_noise_scale <= 63'd65536;
      total_sum         <= '0;
      total_count       <= '0;
    end else begin
      done <= 1'b0;

      // Take configuration transfers
      if (cfg_valid) begin
        case (cfg_index)
          REG_MODE:        mode <= cfg_data[1:0];
          REG_ROW_CAP:     row_cap <= cfg_data[4:0];
          REG_CLIP_LIMIT:  clip_limit <= cfg_data[30:0];
          REG_SUM_SCALE:   sum_noise_scale <= cfg_data[62:0];
          REG_COUNT_SCALE: count_noise_scale <= cfg_data[62:0];
          default: ;
        endcase
      end

      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + UW'(1);
          if (clr_cnt == UW'(MAX_USERS - 1)) begin
            state <= S_IDLE;
            if (clr_report) begin
              done   <= 1'b1;
              status <= ST_TAKEN;
              result <= '0;
            end
          end
        end

        S_IDLE: begin
          if (start) begin
            key_r  <= user_id;
            val_r  <= clip_v;
            draw_r <= pick_draw;
            db_r   <= noise_draw_b;
            case (opcode)
              OP_ADD: begin
                // Home slot is the key modulo the table size
                slot    <= user_id[UW-1:0];
                probe_n <= '0;
                state   <= S_PROBE_RD;
              end
              OP_FINISH: begin
                npos  <= noise_draw_a[31];
                mn    <= noise_mag(noise_draw_a);
                nz    <= '0;
                pass  <= 1'b0;
                if (mode == MODE_COUNT) begin
                  base  <= cnt_q16;
                  scale <= {1'b0, count_noise_scale};
                  state <= N_NORM;
                end else if (mode == MODE_AVG) begin
                  base  <= total_sum;
                  scale <= {sum_noise_scale, 1'b0};
                  if (total_count == '0) begin
                    state  <= S_IDLE;
                    done   <= 1'b1;
                    status <= ST_EMPTY;
                    result <= '0;
                  end else begin
                    state <= N_NORM;
                  end
                end else begin
                  base  <= total_sum;
                  scale <= {1'b0, sum_noise_scale};
                  state <= N_NORM;
                end
              end
              OP_CLEAR: begin
                total_sum   <= '0;
                total_count <= '0;
                clr_cnt     <= '0;
                clr_report  <= 1'b1;
                state       <= S_CLEAR;
              end
              default: begin
                done   <= 1'b1;
                status <= ST_TAKEN;
                result <= '0;
              end
            endcase
          end
        end

        S_DIV: begin
          if (dcnt != 7'd0) begin
            dcnt <= dcnt - 7'd1;
            rem  <= dv_ge ? dv_sub[63:0] : dv_t[63:0];
            quo  <= {quo[78:0], dv_ge};
          end else begin
            unique case (div_op)
              DV_PICK: begin
                if (rem < 64'(cap)) begin
                  val_addr <= slot_base + VW'(rem[KW-1:0]);
                  state    <= S_PICK;
                end else begin
                  state  <= S_IDLE;
                  done   <= 1'b1;
                  status <= ST_TAKEN;
                  result <= '0;
                end
              end
              DV_AVG: begin
                state  <= S_IDLE;
                done   <= 1'b1;
                status <= ST_RESULT;
                if (|quo[79:63]) begin
                  result <= dneg ? SMIN : SMAX;
                end else begin
                  result <= dneg ? -$signed({1'b0, quo[62:0]}) : $signed({1'b0, quo[62:0]});
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end

        S_PROBE_RD: state <= S_PROBE_CHK;

        S_PROBE_CHK: begin
          if (hit) begin
            if (append) begin
              total_sum   <= total_sum + 64'(val_r);
              total_count <= total_count + TCW'(1);
              state       <= S_IDLE;
              done        <= 1'b1;
              status      <= ST_TAKEN;
              result      <= '0;
            end else begin
              quo    <= {draw_r, 48'd0};
              rem    <= '0;
              dvs    <= 64'(seen_n);
              dcnt   <= 7'd32;
              div_op <= DV_PICK;
              state  <= S_DIV;
            end
          end else if (probe_n == UW'(MAX_USERS - 1)) begin
            state  <= S_IDLE;
            done   <= 1'b1;
            status <= ST_DROPPED;
            result <= '0;
          end else begin
            probe_n <= probe_n + UW'(1);
            slot    <= (slot == UW'(MAX_USERS - 1)) ? '0 : slot + UW'(1);
            state   <= S_PROBE_RD;
          end
        end

        S_PICK: state <= S_VAL_RD;

        S_VAL_RD: begin
          total_sum <= total_sum + 64'(val_r) - 64'($signed(val_rdata));
          state     <= S_IDLE;
          done      <= 1'b1;
          status    <= ST_TAKEN;
          result    <= '0;
        end

        // Shift the magnitude up until its top bit is set
        N_NORM: begin
          if (!mn[31]) begin
            mn <= {mn[30:0], 1'b0};
            nz <= nz + 5'd1;
          end else begin
            state <= N_TAB;
          end
        end

        N_TAB: begin
          tabv  <= ln_tab[mn[30 -: LOG_TABLE_BITS]];
          zl    <= 36'(nz) * 36'(LN2_Q30);
          state <= N_LNV;
        end

        N_LNV: begin
          lnv   <= 35'(zl - 36'(tabv));
          acc   <= '0;
          mstep <= 2'd0;
          state <= N_MUL;
        end

        N_MUL: begin
          prod  <= mul_a * mul_b;
          state <= N_ACC;
        end

        N_ACC: begin
          acc <= acc + (128'(prod) << acc_sh);
          if (mstep == 2'd3) begin
            state <= N_SUM;
          end else begin
            mstep <= mstep + 2'd1;
            state <= N_MUL;
          end
        end

        N_SUM: begin
          if (mode == MODE_AVG && !pass) begin
            ns    <= n_sum;
            base  <= cnt_q16;
            scale <= {count_noise_scale, 1'b0};
            pass  <= 1'b1;
            npos  <= db_r[31];
            mn    <= noise_mag(db_r);
            nz    <= '0;
            state <= N_NORM;
          end else if (mode == MODE_AVG) begin
            if (n_sum == 64'd0) begin
              state  <= S_IDLE;
              done   <= 1'b1;
              status <= ST_RESULT;
              if (ns == 64'd0) begin
                result <= '0;
              end else begin
                result <= ns[63] ? SMIN : SMAX;
              end
            end else begin
              quo    <= {(ns[63] ? 64'(-ns) : ns), 16'd0};
              rem    <= '0;
              dvs    <= n_sum[63] ? 64'(-n_sum) : n_sum;
              dneg   <= ns[63] != n_sum[63];
              dcnt   <= 7'd80;
              div_op <= DV_AVG;
              state  <= S_DIV;
            end
          end else begin
            state  <= S_IDLE;
            done   <= 1'b1;
            status <= ST_RESULT;
            result <= n_sum;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // A result only appears once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // Partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < dvs))
    else $error("divider remainder out of range");

  // An empty average reports zero
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> (result == 64'sd0))
    else $error("empty average with nonzero result");

  // Normalizer never runs on a zero magnitude
  a_norm_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == N_NORM) |-> (mn != 32'd0))
    else $error("noise magnitude is zero");

endmodule
